[hdl/crip_pkg.sv]
// shared constants and types for the checked radix integer parser
// no dependencies; used by crip_cfg, crip_scan, the parser top and the bench
`timescale 1ns / 1ps
`default_nettype none

package crip_pkg;

    localparam int DEFAULT_MAX_BITS = 64;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 7;
    localparam int BITS_W           = 7;
    localparam int VALUE_W          = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP  = 2'd3;

    // radix codes
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_INVALID  = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW = 2'd3;

    // register reset values
    localparam logic [1:0]        RST_RADIX  = RADIX_DEC;
    localparam logic              RST_SIGNED = 1'b1;
    localparam logic [BITS_W-1:0] RST_BITS   = 7'd32;
    localparam logic              RST_STRIP  = 1'b0;
    localparam logic [BITS_W-1:0] MIN_BITS   = 7'd8;

    typedef struct packed {
        logic [1:0]        radix_code;
        logic              signed_result;
        logic [BITS_W-1:0] eff_bits;
        logic              strip_hex_prefix;
    } t_cfg;

    typedef struct packed {
        logic [VALUE_W-1:0] parsed_value;
        logic [1:0]         parse_status;
    } t_result;

endpackage

`default_nettype wire

[hdl/crip_in_if.sv]
// character request channel of the parser
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface crip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[hdl/crip_out_if.sv]
// result request channel of the parser
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface crip_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] parsed_value;
    logic [1:0]  parse_status;

    modport source (output valid, output parsed_value, output parse_status, input ready);
    modport sink   (input valid, input parsed_value, input parse_status, output ready);
endinterface

`default_nettype wire

[hdl/checked_radix_integer_parser.sv]
// path: an accepted character request passes the input register and then the result register
// throughput: one character per cycle while the result slot is free or being drained;
//   per-character shift-add and limit compare are combinational; scan state moves each step
// reset: synchronous, active low; registers return to decimal, signed, 32 bits, no prefix
//   strip, and the scan state returns to the start of a string
// depends on crip_pkg, crip_in_if, crip_out_if, crip_cfg, crip_scan
`timescale 1ns / 1ps
`default_nettype none

module checked_radix_integer_parser #(
    parameter int MAX_BITS = crip_pkg::DEFAULT_MAX_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [crip_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [crip_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    crip_in_if.sink                          i_in,
    crip_out_if.source                       o_out
);

    // input stage holding one character request
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result stage
    logic              r_out_valid;
    crip_pkg::t_result r_out;

    crip_pkg::t_cfg    cfg;
    crip_pkg::t_result scan_res;

    logic advance;
    logic step;

    // the pipeline moves whenever the result slot is free or being drained
    assign advance     = !r_out_valid || o_out.ready;
    assign step        = advance && r_in_valid;
    assign i_in.ready  = !r_in_valid || advance;

    crip_cfg #(
        .MAX_BITS (MAX_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    crip_scan #(
        .MAX_BITS (MAX_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_text_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .i_cfg       (cfg),
        .o_result    (scan_res)
    );

    // input register: takes a new request whenever it is empty or its content moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.text_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // result register: only the last character of a string produces a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= scan_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.parsed_value = r_out.parsed_value;
    assign o_out.parse_status = r_out.parse_status;

endmodule

`default_nettype wire

[hdl/crip_cfg.sv]
// configuration registers and width clamping for the parser
// depends on crip_pkg
`timescale 1ns / 1ps
`default_nettype none

module crip_cfg #(
    parameter int MAX_BITS = crip_pkg::DEFAULT_MAX_BITS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [crip_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [crip_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output crip_pkg::t_cfg                     o_cfg
);

    logic [1:0]                    r_radix;
    logic                          r_signed;
    logic [crip_pkg::BITS_W-1:0]   r_bits;
    logic                          r_strip;
    logic [crip_pkg::BITS_W-1:0]   eff_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= crip_pkg::RST_RADIX;
            r_signed <= crip_pkg::RST_SIGNED;
            r_bits   <= crip_pkg::RST_BITS;
            r_strip  <= crip_pkg::RST_STRIP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                crip_pkg::CFG_RADIX:  r_radix  <= i_cfg_wdata[1:0];
                crip_pkg::CFG_SIGNED: r_signed <= i_cfg_wdata[0];
                crip_pkg::CFG_BITS:   r_bits   <= i_cfg_wdata;
                crip_pkg::CFG_STRIP:  r_strip  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // clamp target width into 8..MAX_BITS
    always_comb begin
        if (r_bits < crip_pkg::MIN_BITS) begin
            eff_bits = crip_pkg::MIN_BITS;
        end else if (r_bits > crip_pkg::BITS_W'(MAX_BITS)) begin
            eff_bits = crip_pkg::BITS_W'(MAX_BITS);
        end else begin
            eff_bits = r_bits;
        end
    end

    assign o_cfg.radix_code       = r_radix;
    assign o_cfg.signed_result    = r_signed;
    assign o_cfg.eff_bits         = eff_bits;
    assign o_cfg.strip_hex_prefix = r_strip;

endmodule

`default_nettype wire

[hdl/crip_scan.sv]
// per-character scan state and next-state logic, with result formatting
// depends on crip_pkg
`timescale 1ns / 1ps
`default_nettype none

module crip_scan #(
    parameter int MAX_BITS = crip_pkg::DEFAULT_MAX_BITS
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_step,
    input  wire  [7:0]       i_text_byte,
    input  wire              i_last_byte,
    input  crip_pkg::t_cfg   i_cfg,
    output crip_pkg::t_result o_result
);

    localparam int PW = MAX_BITS + 4;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SPACE  = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_PREFIX = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_ENDED  = 3'd5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    logic [MAX_BITS-1:0] r_acc, n_acc;
    logic [2:0]          r_phase, n_phase;
    logic                r_neg, n_neg;
    logic [1:0]          r_err, n_err;

    logic [MAX_BITS-1:0] one_v;
    logic [MAX_BITS-1:0] lim;
    logic [PW-1:0]       lim_x;
    logic [PW-1:0]       prod;
    logic [PW-1:0]       sum;
    logic [4:0]          base;
    logic [3:0]          dval;
    logic                dhit;
    logic                d_ok;
    logic                ovf_pre;
    logic                ovf_add;
    logic                blank_chr;
    logic                do_space;
    logic                do_digit;
    logic [7:0]          c;

    logic [63:0]         acc64;
    logic [63:0]         val;
    logic [63:0]         m64;
    logic [5:0]          sign_idx;

    assign c     = i_text_byte;
    assign one_v = MAX_BITS'(1);

    // overflow limit for the target type
    always_comb begin
        if (i_cfg.signed_result) begin
            lim = (one_v << (i_cfg.eff_bits - 7'd1)) - (r_neg ? '0 : one_v);
        end else begin
            lim = (one_v << i_cfg.eff_bits) - one_v;
        end
        lim_x = PW'(lim);
    end

    // digit decode
    always_comb begin
        dval = 4'd0;
        dhit = 1'b0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            dval = 4'(c - CH_ZERO);
            dhit = 1'b1;
        end else if (c >= CH_LA && c <= CH_LF) begin
            dval = 4'(c - CH_LA + 8'd10);
            dhit = 1'b1;
        end else if (c >= CH_UA && c <= CH_UF) begin
            dval = 4'(c - CH_UA + 8'd10);
            dhit = 1'b1;
        end
    end

    // accumulator times base as shifts, plus an add for decimal
    always_comb begin
        case (i_cfg.radix_code)
            crip_pkg::RADIX_BIN: begin
                base = 5'd2;
                prod = {3'b000, r_acc, 1'b0};
            end
            crip_pkg::RADIX_OCT: begin
                base = 5'd8;
                prod = {1'b0, r_acc, 3'b000};
            end
            crip_pkg::RADIX_DEC: begin
                base = 5'd10;
                prod = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
            end
            default: begin
                base = 5'd16;
                prod = {r_acc, 4'b0000};
            end
        endcase
    end

    assign d_ok      = dhit && ({1'b0, dval} < base);
    assign sum       = prod + PW'(dval);
    // acc > lim/base is the same as acc*base > lim
    assign ovf_pre   = prod > lim_x;
    assign ovf_add   = sum > lim_x;
    assign blank_chr = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;

    always_comb begin
        n_acc    = r_acc;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_err    = r_err;
        do_space = 1'b0;
        do_digit = 1'b0;

        if (r_err == crip_pkg::STAT_OK) begin
            unique case (r_phase) inside
                PH_START: begin
                    if (i_cfg.strip_hex_prefix && c == CH_ZERO) begin
                        n_phase = PH_ZERO;
                    end else begin
                        do_space = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (c == CH_LX || c == CH_UX) begin
                        n_phase = PH_PREFIX;
                    end else begin
                        n_phase  = PH_DIGITS;
                        do_digit = 1'b1;
                    end
                end
                PH_PREFIX, PH_SPACE: do_space = 1'b1;
                PH_DIGITS:           do_digit = 1'b1;
                default: ;
            endcase
        end

        if (do_space) begin
            if (blank_chr) begin
                n_phase = PH_SPACE;
            end else if (c == CH_NUL) begin
                n_err = crip_pkg::STAT_EMPTY;
            end else if (c == CH_MINUS) begin
                if (i_cfg.radix_code == crip_pkg::RADIX_DEC && i_cfg.signed_result) begin
                    n_neg   = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    n_err = crip_pkg::STAT_INVALID;
                end
            end else begin
                n_phase = PH_DIGITS;
                if (c != CH_PLUS) begin
                    do_digit = 1'b1;
                end
            end
        end

        if (do_digit) begin
            if (c == CH_NUL) begin
                n_phase = PH_ENDED;
            end else if (ovf_pre) begin
                n_err = crip_pkg::STAT_OVERFLOW;
            end else if (!d_ok) begin
                n_err = crip_pkg::STAT_INVALID;
            end else if (ovf_add) begin
                n_err = crip_pkg::STAT_OVERFLOW;
            end else begin
                n_acc = sum[MAX_BITS-1:0];
            end
        end
    end

    // result formatting from the updated state
    always_comb begin
        acc64    = 64'(n_acc);
        m64      = (64'd1 << i_cfg.eff_bits) - 64'd1;
        sign_idx = 6'(i_cfg.eff_bits - 7'd1);
        val      = 64'd0;
        o_result.parse_status = crip_pkg::STAT_OK;
        if (n_err != crip_pkg::STAT_OK) begin
            o_result.parse_status = n_err;
        end else if (n_phase == PH_START || n_phase == PH_SPACE) begin
            o_result.parse_status = crip_pkg::STAT_EMPTY;
        end else if (n_phase == PH_PREFIX) begin
            o_result.parse_status = crip_pkg::STAT_INVALID;
        end else if (i_cfg.signed_result || n_neg) begin
            val = (n_neg ? (64'd0 - acc64) : acc64) & m64;
            if (val[sign_idx]) begin
                val = val | ~m64;
            end
        end else begin
            val = acc64;
        end
        o_result.parsed_value = val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_phase <= PH_START;
            r_neg   <= 1'b0;
            r_err   <= crip_pkg::STAT_OK;
        end else if (i_step) begin
            if (i_last_byte) begin
                r_acc   <= '0;
                r_phase <= PH_START;
                r_neg   <= 1'b0;
                r_err   <= crip_pkg::STAT_OK;
            end else begin
                r_acc   <= n_acc;
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_err   <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

[bench/crip_parse_check.sv]
// result checker for the checked radix integer parser: keeps its own copy of the
// config registers, predicts each string's result and compares it with the result requests
// depends on crip_pkg, crip_in_if and crip_out_if
`timescale 1ns / 1ps

module crip_parse_check
    import crip_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_wdata,
    crip_in_if                    i_chr,
    crip_out_if                   i_res,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_SPACE,
        SCAN_ZERO,
        SCAN_PREFIX,
        SCAN_DIGITS,
        SCAN_ENDED
    } t_scan;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] NO_DIGIT = 8'hFF;

    logic [1:0]        cfg_radix;
    logic              cfg_signed;
    logic [BITS_W-1:0] cfg_width;
    logic              cfg_strip;

    logic [63:0] num_acc;
    t_scan       scan_st;
    logic        minus_seen;
    logic [1:0]  fault_code;

    t_result awaited_parses[$];
    int      fails = 0;

    function automatic logic [63:0] radix_base();
        case (cfg_radix)
            RADIX_BIN: return 64'd2;
            RADIX_OCT: return 64'd8;
            RADIX_DEC: return 64'd10;
            default:   return 64'd16;
        endcase
    endfunction

    // widths outside the legal range are clamped
    function automatic int target_width();
        if (cfg_width < MIN_BITS) return MIN_BITS;
        if (cfg_width > DEFAULT_MAX_BITS) return DEFAULT_MAX_BITS;
        return cfg_width;
    endfunction

    function automatic logic [63:0] width_ones(input int w);
        return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic [63:0] magnitude_limit();
        logic [63:0] lim;
        if (cfg_signed) begin
            lim = (64'd1 << (target_width() - 1)) - 64'd1;
            if (minus_seen) lim = lim + 64'd1;
        end else begin
            lim = width_ones(target_width());
        end
        return lim;
    endfunction

    function automatic logic [7:0] digit_of(input logic [7:0] c, input logic [63:0] base);
        logic [7:0] d;
        if (c >= CH_0 && c <= CH_9) d = c - CH_0;
        else if (c >= CH_LA && c <= CH_LF) d = c - CH_LA + 8'd10;
        else if (c >= CH_UA && c <= CH_UF) d = c - CH_UA + 8'd10;
        else return NO_DIGIT;
        return ({56'd0, d} < base) ? d : NO_DIGIT;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    endfunction

    task automatic restart_scan();
        num_acc    = '0;
        scan_st    = SCAN_START;
        minus_seen = 1'b0;
        fault_code = STAT_OK;
    endtask

    // overflow is checked before the digit itself is looked at
    task automatic accumulate_digit(input logic [7:0] c);
        logic [63:0] base;
        logic [63:0] lim;
        logic [7:0]  d;
        base = radix_base();
        lim  = magnitude_limit();
        if (c == CH_NUL) begin
            scan_st = SCAN_ENDED;
            return;
        end
        if (num_acc > lim / base) begin
            fault_code = STAT_OVERFLOW;
            return;
        end
        num_acc = num_acc * base;
        d = digit_of(c, base);
        if (d == NO_DIGIT) begin
            fault_code = STAT_INVALID;
            return;
        end
        if (lim - num_acc < {56'd0, d}) begin
            fault_code = STAT_OVERFLOW;
            return;
        end
        num_acc = num_acc + {56'd0, d};
    endtask

    task automatic lead_char(input logic [7:0] c);
        if (is_blank(c)) begin
            scan_st = SCAN_SPACE;
            return;
        end
        if (c == CH_NUL) begin
            fault_code = STAT_EMPTY;
            return;
        end
        if (c == CH_MINUS) begin
            if (cfg_radix == RADIX_DEC && cfg_signed) begin
                minus_seen = 1'b1;
                scan_st    = SCAN_DIGITS;
            end else begin
                fault_code = STAT_INVALID;
            end
            return;
        end
        scan_st = SCAN_DIGITS;
        if (c != CH_PLUS) accumulate_digit(c);
    endtask

    task automatic scan_char(input logic [7:0] c);
        if (fault_code != STAT_OK) return;
        case (scan_st)
            SCAN_START: begin
                if (cfg_strip && c == CH_0) scan_st = SCAN_ZERO;
                else lead_char(c);
            end
            SCAN_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    scan_st = SCAN_PREFIX;
                end else begin
                    scan_st = SCAN_DIGITS;
                    num_acc = '0;
                    accumulate_digit(c);
                end
            end
            SCAN_PREFIX, SCAN_SPACE: lead_char(c);
            SCAN_DIGITS: accumulate_digit(c);
            default: ;
        endcase
    endtask

    function automatic t_result string_result();
        t_result     r;
        int          w;
        logic [63:0] ones;
        r.parsed_value = '0;
        r.parse_status = STAT_OK;
        if (fault_code != STAT_OK) begin
            r.parse_status = fault_code;
        end else if (scan_st == SCAN_START || scan_st == SCAN_SPACE) begin
            r.parse_status = STAT_EMPTY;
        end else if (scan_st == SCAN_PREFIX) begin
            r.parse_status = STAT_INVALID;
        end else if (cfg_signed || minus_seen) begin
            w    = target_width();
            ones = width_ones(w);
            r.parsed_value = (minus_seen ? (64'd0 - num_acc) : num_acc) & ones;
            if (r.parsed_value[w-1]) r.parsed_value = r.parsed_value | ~ones;
        end else begin
            r.parsed_value = num_acc;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg_radix  = RST_RADIX;
            cfg_signed = RST_SIGNED;
            cfg_width  = RST_BITS;
            cfg_strip  = RST_STRIP;
            restart_scan();
            awaited_parses.delete();
        end else begin
            // character request: the step uses the registers as they were before this edge
            if (i_chr.valid && i_chr.ready) begin
                scan_char(i_chr.text_byte);
                if (i_chr.last_byte) begin
                    awaited_parses.push_back(string_result());
                    restart_scan();
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIX:  cfg_radix  = i_cfg_wdata[1:0];
                    CFG_SIGNED: cfg_signed = i_cfg_wdata[0];
                    CFG_BITS:   cfg_width  = i_cfg_wdata[BITS_W-1:0];
                    CFG_STRIP:  cfg_strip  = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                got.parsed_value = i_res.parsed_value;
                got.parse_status = i_res.parse_status;
                if (awaited_parses.size() == 0) begin
                    $error("result request with no string pending: value %h status %0d",
                           got.parsed_value, got.parse_status);
                    fails++;
                end else begin
                    want = awaited_parses.pop_front();
                    if (got.parsed_value !== want.parsed_value) begin
                        $error("parsed_value mismatch: expected %h, got %h",
                               want.parsed_value, got.parsed_value);
                        fails++;
                    end
                    if (got.parse_status !== want.parse_status) begin
                        $error("parse_status mismatch: expected %0d, got %0d",
                               want.parse_status, got.parse_status);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= awaited_parses.size();
        o_fail_count <= fails;
    end

endmodule

[bench/tb_checked_radix_integer_parser.sv]
// testbench top for checked_radix_integer_parser: clock, reset, register writes,
// character and result request traffic and the verdict
// depends on crip_pkg, crip_in_if, crip_out_if, the parser and crip_parse_check
`timescale 1ns / 1ps

module tb_checked_radix_integer_parser;
    import crip_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;     // result register depth plus margin
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 9;
    localparam int PHASE_CHARS   = 45;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count;
    int                    pending_results;

    // what was last written to the registers, so strings can be shaped to fit
    logic [1:0]        cur_radix;
    logic              cur_signed;
    logic [BITS_W-1:0] cur_bits;
    logic              cur_strip;

    logic [7:0] text_q[$];    // characters of the string being built
    int         chars_sent;
    bit         hold_wanted;

    crip_in_if  chr_req();
    crip_out_if res_req();

    checked_radix_integer_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (chr_req),
        .o_out       (res_req)
    );

    crip_parse_check parse_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_chr        (chr_req),
        .i_res        (res_req),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return CH_0 + 8'(d);
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10);
    endfunction

    function automatic int base_count();
        case (cur_radix)
            RADIX_BIN: return 2;
            RADIX_OCT: return 8;
            RADIX_DEC: return 10;
            default:   return 16;
        endcase
    endfunction

    // digits needed to reach the width limit in the current base
    function automatic int max_digits();
        int w;
        w = (cur_bits < MIN_BITS) ? MIN_BITS : ((cur_bits > 64) ? 64 : cur_bits);
        case (cur_radix)
            RADIX_BIN: return w;
            RADIX_OCT: return (w + 2) / 3;
            RADIX_DEC: return (w * 3 + 9) / 10;
            default:   return (w + 3) / 4;
        endcase
    endfunction

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    endtask

    // one character request per queued byte, the mark on the final one
    task automatic send_string();
        int gap;
        bit calm;
        calm = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < text_q.size(); k++) begin
            gap = calm ? 0 : gap_length();
            if (gap > 0) begin
                chr_req.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            chr_req.valid     <= 1'b1;
            chr_req.text_byte <= text_q[k];
            chr_req.last_byte <= (k == text_q.size() - 1);
            @(posedge i_clk);
            while (!chr_req.ready) @(posedge i_clk);
            chars_sent++;
        end
        text_q.delete();
    endtask

    task automatic send_text(input string s);
        put_text(s);
        send_string();
    endtask

    // stop offering, let every result come back, then let the pipe settle
    task automatic wait_idle();
        chr_req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [1:0] radix, input logic sgn,
                              input logic [BITS_W-1:0] bits, input logic strip);
        cur_radix  = radix;
        cur_signed = sgn;
        cur_bits   = bits;
        cur_strip  = strip;
        write_reg(CFG_RADIX, CFG_DATA_W'(radix));
        write_reg(CFG_SIGNED, CFG_DATA_W'(sgn));
        write_reg(CFG_BITS, CFG_DATA_W'(bits));
        write_reg(CFG_STRIP, CFG_DATA_W'(strip));
    endtask

    // mostly well-formed numbers (prefix, blanks, sign, digits) with some lengths
    // right at the overflow edge; the rest is raw noise or damaged strings
    task automatic make_string();
        int ndig;
        int maxd;
        int base;
        int d;
        int pos;
        int r;
        bit near_max;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (cur_strip && $urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 1)) put_text("0x");
            else put_text("0X");
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) text_q.push_back(blank_char());
        // minus mostly where it is legal, now and then where it is not
        r = $urandom_range(0, 9);
        if (r < 3 && ((cur_radix == RADIX_DEC && cur_signed) || r == 0))
            text_q.push_back(CH_MINUS);
        else if (r < 5)
            text_q.push_back(CH_PLUS);
        maxd     = max_digits();
        base     = base_count();
        near_max = ($urandom_range(0, 99) < ((maxd > 16) ? 5 : 30));
        ndig     = near_max ? $urandom_range(maxd - 1, maxd + 1)
                            : $urandom_range(0, (maxd < 8) ? maxd : 8);
        for (int k = 0; k < ndig; k++) begin
            d = (near_max && $urandom_range(0, 1)) ? base - 1 : $urandom_range(0, base - 1);
            text_q.push_back(digit_char(d));
        end
        if (text_q.size() == 0) text_q.push_back($urandom_range(0, 1) ? CH_NUL : blank_char());
        // damage: stray byte, stray blank, or an early terminator with trailing junk
        r   = $urandom_range(0, 99);
        pos = $urandom_range(0, text_q.size() - 1);
        if (r < 10) begin
            text_q[pos] = 8'($urandom_range(0, 255));
        end else if (r < 15) begin
            text_q[pos] = blank_char();
        end else if (r < 20) begin
            text_q.insert(pos, CH_NUL);
            repeat ($urandom_range(1, 2)) text_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int phase_end;
        int bits_pick;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_RADIX;
        cfg_wdata         <= '0;
        chr_req.valid     <= 1'b0;
        chr_req.text_byte <= CH_NUL;
        chr_req.last_byte <= 1'b0;
        i_rst_n           <= 1'b0;
        cur_radix   = RST_RADIX;
        cur_signed  = RST_SIGNED;
        cur_bits    = RST_BITS;
        cur_strip   = RST_STRIP;
        chars_sent  = 0;
        hold_wanted = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: decimal, signed, 32 bits, no prefix strip
        send_text("-");                 // lone minus reads as zero
        send_text("+");                 // lone plus too
        text_q.push_back(CH_NUL);       // terminator before anything: empty
        send_string();
        send_text("\t ");               // blanks only: empty
        // everything after the terminator is ignored, top-bit byte included
        put_text("7");
        text_q.push_back(CH_NUL);
        text_q.push_back(8'hFF);
        send_string();
        send_text("1 ");                // blank after a digit is invalid
        wait_idle();

        // hex, unsigned, width under the floor so it acts as 8, prefix strip on
        set_config(RADIX_HEX, 1'b0, 7'd3, 1'b1);
        send_text("0x");                // bare prefix is not stripped: invalid
        send_text("0XfF");              // stripped prefix, then the full 8-bit range
        send_text("10g");               // limit already passed, so overflow wins over the bad digit
        send_text("0");                 // zero held as a maybe-prefix, ends as plain zero
        wait_idle();

        // random strings under a series of settings, extremes first
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_config(RADIX_BIN, 1'b0, 7'd8, 1'b0);
                1: set_config(RADIX_OCT, 1'b1, 7'd64, 1'b1);
                2: set_config(RADIX_DEC, 1'b1, 7'd8, 1'b0);
                3: set_config(RADIX_HEX, 1'b0, 7'd64, 1'b1);
                4: set_config(RADIX_DEC, 1'b0, 7'd127, 1'b0);   // over the top, acts as 64
                5: set_config(RADIX_DEC, 1'b1, 7'd0, 1'b1);     // zero width, acts as 8
                default: begin
                    case ($urandom_range(0, 9))
                        0:       bits_pick = $urandom_range(0, 7);
                        1:       bits_pick = $urandom_range(65, 127);
                        default: bits_pick = $urandom_range(8, 64);
                    endcase
                    set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               BITS_W'(bits_pick), 1'($urandom_range(0, 1)));
                end
            endcase
            // one long result hold-off while characters keep being offered
            if (ph == 1) hold_wanted = 1'b1;
            phase_end = chars_sent + PHASE_CHARS;
            while (chars_sent < phase_end) begin
                make_string();
                send_string();
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // result request side: random stalls, calm stretches, one long hold-off
    initial begin : result_sink
        int stall_left;
        int calm_left;
        bit hold_taken;
        res_req.ready <= 1'b0;
        stall_left = 0;
        calm_left  = 0;
        hold_taken = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_wanted && !hold_taken) begin
                hold_taken = 1'b1;
                res_req.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (calm_left > 0) begin
                    calm_left--;
                    res_req.ready <= 1'b1;
                end else if (stall_left > 0) begin
                    stall_left--;
                    res_req.ready <= 1'b0;
                end else begin
                    res_req.ready <= 1'b1;
                    if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(30, 120);
                    else stall_left = gap_length();
                end
                @(posedge i_clk);
            end
        end
    end

    // hang guard
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
hdl/crip_pkg.sv
hdl/crip_in_if.sv
hdl/crip_out_if.sv
hdl/crip_cfg.sv
hdl/crip_scan.sv
hdl/checked_radix_integer_parser.sv
bench/crip_parse_check.sv
bench/tb_checked_radix_integer_parser.sv
